>>> sv/jgdc_pkg.sv
// jgdc_pkg: field widths, calendar constants, month tables and the divide-by-100 helper
// used by the channel interfaces and julian_gregorian_day_count_core
// no dependencies
`default_nettype none

package jgdc_pkg;

  localparam int YEAR_W  = 13;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 10;
  localparam int COUNT_W = 22;
  localparam int WDAY_W  = 4;

  localparam int REFORM_YEAR    = 1582;
  localparam int REFORM_MONTH   = 10;
  localparam int FIRST_DROP_DAY = 5;
  localparam int LAST_DROP_DAY  = 14;
  localparam int GREG_SHIFT     = 10;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int WEEK_DAYS      = 7;

  // floor(a / 100) via reciprocal 5243 / 2^19; div100 returns six bits, so it is exact for a < 6400
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_JULIAN    = 2'd1,
    KIND_GREGORIAN = 2'd2
  } date_kind_t;

  typedef logic [3:0]  month_t;
  typedef logic [5:0]  q100_t;

  function automatic logic [5:0] month_len(input month_t m);
    logic [5:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 6'd30;
      4'd2:                                       len = 6'd28;
      default:                                    len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input month_t m);
    logic [8:0] n;
    case (m)
      4'd0, 4'd1: n = 9'd0;
      4'd2:       n = 9'd31;
      4'd3:       n = 9'd59;
      4'd4:       n = 9'd90;
      4'd5:       n = 9'd120;
      4'd6:       n = 9'd151;
      4'd7:       n = 9'd181;
      4'd8:       n = 9'd212;
      4'd9:       n = 9'd243;
      4'd10:      n = 9'd273;
      4'd11:      n = 9'd304;
      4'd12:      n = 9'd334;
      default:    n = 9'd365;
    endcase
    return n;
  endfunction

  function automatic q100_t div100(input logic [12:0] a);
    logic [25:0] p;
    p = 26'(a) * 26'(DIV100_MUL);
    return p[DIV100_SHIFT+5:DIV100_SHIFT];
  endfunction

endpackage

`default_nettype wire

>>> sv/jgdc_in_if.sv
// jgdc_in_if: date item channel (valid, ready, year, month, day)
// depends on jgdc_pkg
`default_nettype none

interface jgdc_in_if import jgdc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0]        month;
  logic [DAY_W-1:0]          day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink   (input valid, input year, input month, input day, output ready);
endinterface

`default_nettype wire

>>> sv/jgdc_out_if.sv
// jgdc_out_if: result item channel (valid, ready, date_kind, day_of_year, day_count, weekday)
// depends on jgdc_pkg
`default_nettype none

interface jgdc_out_if import jgdc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 date_kind;
  logic signed [DOY_W-1:0]    day_of_year;
  logic signed [COUNT_W-1:0]  day_count;
  logic signed [WDAY_W-1:0]   weekday;

  modport source (output valid, output date_kind, output day_of_year, output day_count,
                  output weekday, input ready);
  modport sink   (input valid, input date_kind, input day_of_year, input day_count,
                  input weekday, output ready);
endinterface

`default_nettype wire

>>> sv/julian_gregorian_day_count_core.sv
// julian_gregorian_day_count_core: date classifier, day of year, day count and weekday
// depends on jgdc_pkg, jgdc_in_if, jgdc_out_if
//
//   channel  dir  fields
//   in_if    in   year, month, day
//   out_if   out  date_kind, day_of_year, day_count, weekday
//
// four register stages: input, kind/doy/quotients, day count, weekday and result
// one item per cycle while out_if.ready is high; items pass the stages in order
// each stage loads when empty or when the stage after it moves, so out_if.ready low
// holds the whole pipe; in_if.ready follows from that chain in the same cycle
// synchronous active-low reset clears the stage valid bits only
`default_nettype none

module julian_gregorian_day_count_core import jgdc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  jgdc_in_if.sink     in_if,
  jgdc_out_if.source  out_if
);

  // stage enables and valid bits
  logic v0_r, v1_r, v2_r, v3_r;
  logic en0, en1, en2, en3;

  assign en3 = !v3_r || out_if.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_if.ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_if.valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // input register
  logic signed [YEAR_W-1:0] year_r;
  logic [MONTH_W-1:0]       month_r;
  logic [DAY_W-1:0]         day_r;

  always_ff @(posedge clk) begin
    if (en0 && in_if.valid) begin
      year_r  <= in_if.year;
      month_r <= in_if.month;
      day_r   <= in_if.day;
    end
  end

  // stage 1: classification, day of year, quotients of year - 1
  logic [12:0]        yabs;
  q100_t              y_q100;
  logic [12:0]        y_mul100;
  logic               y_div4, y_div100, y_div400;
  logic               jul_leap, greg_leap;
  logic               is_reform, after_reform, reform_oct;
  logic               leap_chk, leap_doy;
  logic [5:0]         mlen;
  logic               month_ok, day_ok, dropped;
  date_kind_t         kind_nxt;
  logic [9:0]         doy_base;
  logic signed [9:0]  doy_nxt;
  logic signed [13:0] ym1_nxt;
  logic               ym1_neg;
  logic [12:0]        ym1abs;
  q100_t              ym_q100;
  logic [3:0]         ym_q400;
  logic [10:0]        ym_q4;
  logic signed [11:0] q4_nxt;
  logic signed [7:0]  adj_base, adj_nxt;

  always_comb begin
    yabs     = year_r[YEAR_W-1] ? 13'(~year_r + 13'd1) : 13'(year_r);
    y_q100   = div100(yabs);
    y_mul100 = 13'({7'd0, y_q100}) * 13'd100;
    y_div4   = (year_r[1:0] == 2'd0);
    y_div100 = (yabs == y_mul100);
    y_div400 = y_div100 && (y_q100[1:0] == 2'd0);
    jul_leap  = y_div4;
    greg_leap = y_div400 || (y_div4 && !y_div100);

    is_reform    = (year_r == 13'(REFORM_YEAR));
    after_reform = (year_r > 13'(REFORM_YEAR));
    reform_oct   = is_reform && (month_r == 4'(REFORM_MONTH));
    dropped      = reform_oct && (day_r >= 5'(FIRST_DROP_DAY)) && (day_r <= 5'(LAST_DROP_DAY));

    leap_chk = (after_reform || (is_reform && month_r > 4'(REFORM_MONTH)) ||
                (reform_oct && day_r > 5'(LAST_DROP_DAY))) ? greg_leap : jul_leap;
    mlen     = month_len(month_r) + 6'((month_r == 4'd2) && leap_chk);
    month_ok = (month_r >= 4'd1) && (month_r <= 4'd12);
    day_ok   = month_ok && (day_r != 5'd0) && ({1'b0, day_r} <= mlen);

    if (after_reform || (is_reform && month_r > 4'(REFORM_MONTH)) ||
        (reform_oct && day_r > 5'(LAST_DROP_DAY))) begin
      kind_nxt = day_ok ? KIND_GREGORIAN : KIND_NONE;
    end else if (dropped) begin
      kind_nxt = KIND_NONE;
    end else begin
      kind_nxt = day_ok ? KIND_JULIAN : KIND_NONE;
    end

    leap_doy = (kind_nxt == KIND_JULIAN) ? jul_leap : greg_leap;
    doy_base = 10'(days_before(month_r)) + 10'(day_r) +
               10'(leap_doy && (month_r >= 4'd3));
    doy_nxt  = $signed(doy_base);
    if (is_reform) begin
      if (kind_nxt == KIND_GREGORIAN) doy_nxt = $signed(doy_base) - 10'sd10;
      if (kind_nxt == KIND_NONE)      doy_nxt = -10'sd1;
    end

    ym1_nxt = {year_r[YEAR_W-1], year_r} - 14'sd1;
    ym1_neg = ym1_nxt[13];
    ym1abs  = ym1_neg ? 13'(~ym1_nxt + 14'd1) : 13'(ym1_nxt);
    ym_q4   = ym1abs[12:2];
    ym_q100 = div100(ym1abs);
    ym_q400 = ym_q100[5:2];
    q4_nxt  = ym1_neg ? -$signed({1'b0, ym_q4}) : $signed({1'b0, ym_q4});
    adj_base = ym1_neg ? ($signed({2'b0, ym_q100}) - $signed({4'b0, ym_q400}))
                       : ($signed({4'b0, ym_q400}) - $signed({2'b0, ym_q100}));
    adj_nxt  = after_reform ? adj_base + 8'sd2 : 8'sd0;
  end

  date_kind_t         kind1_r;
  logic signed [9:0]  doy1_r;
  logic signed [13:0] ym1_r;
  logic signed [11:0] q4_r;
  logic signed [7:0]  adj_r;

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      kind1_r <= kind_nxt;
      doy1_r  <= doy_nxt;
      ym1_r   <= ym1_nxt;
      q4_r    <= q4_nxt;
      adj_r   <= adj_nxt;
    end
  end

  // stage 2: day count
  logic signed [COUNT_W-1:0] ym1_ext, count_nxt;

  always_comb begin
    ym1_ext   = COUNT_W'(ym1_r);
    count_nxt = COUNT_W'(ym1_ext * COUNT_W'(DAYS_PER_YEAR)) + COUNT_W'(q4_r) +
                COUNT_W'(doy1_r) + COUNT_W'(adj_r) - COUNT_W'(2);
  end

  date_kind_t                kind2_r;
  logic signed [9:0]         doy2_r;
  logic signed [COUNT_W-1:0] count2_r;

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      kind2_r  <= kind1_r;
      doy2_r   <= doy1_r;
      count2_r <= count_nxt;
    end
  end

  // stage 3: truncating remainder 7 by octal digit folding
  logic [23:0]              cabs;
  logic [5:0]               dsum;
  logic [3:0]               fold;
  logic [2:0]               rem7;
  logic signed [WDAY_W-1:0] wday_nxt;

  always_comb begin
    cabs = count2_r[COUNT_W-1] ? 24'(~count2_r + COUNT_W'(1)) : 24'(count2_r);
    dsum = 6'd0;
    for (int i = 0; i < 8; i++) begin
      dsum = dsum + 6'(cabs[3*i +: 3]);
    end
    fold = 4'(dsum[5:3]) + 4'(dsum[2:0]);
    rem7 = (fold >= 4'(WEEK_DAYS)) ? 3'(fold - 4'(WEEK_DAYS)) : fold[2:0];
    wday_nxt = count2_r[COUNT_W-1] ? -$signed({1'b0, rem7}) : $signed({1'b0, rem7});
  end

  date_kind_t                kind3_r;
  logic signed [9:0]         doy3_r;
  logic signed [COUNT_W-1:0] count3_r;
  logic signed [WDAY_W-1:0]  wday3_r;

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      kind3_r  <= kind2_r;
      doy3_r   <= doy2_r;
      count3_r <= count2_r;
      wday3_r  <= wday_nxt;
    end
  end

  assign out_if.valid       = v3_r;
  assign out_if.date_kind   = kind3_r;
  assign out_if.day_of_year = doy3_r;
  assign out_if.day_count   = count3_r;
  assign out_if.weekday     = wday3_r;

endmodule

`default_nettype wire
